// ===== src/bgs_pkg.sv =====
package bgs_pkg;
  localparam int unsigned MaxGroupDef = 16;
  localparam logic [4:0] GroupSizeRst = 5'd16;
  localparam logic [31:0] QNanDef = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit = 32'h0040_0000;

  function automatic logic is_nan32(input logic [31:0] x);
    is_nan32 = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_snan32(input logic [31:0] x);
    is_snan32 = is_nan32(x) && !x[22];
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] x);
    logic [32:0] s;
    begin
      s = {1'b0, x} + 33'h0_7FFF + {32'd0, x[16]};
      if (is_nan32(x)) to_bf16 = x[31:16] | 16'h0040;
      else to_bf16 = s[31:16];
    end
  endfunction
endpackage

// ===== src/bgs_fp32_add.sv =====
module bgs_fp32_add (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import bgs_pkg::*;

  logic [31:0] x, z;
  logic [7:0]  ex, ez, d;
  logic [26:0] mx, mz, mzs, mzm;
  logic [27:0] sum;
  logic [26:0] m;
  logic [8:0]  e;
  logic [4:0]  lz;
  logic [8:0]  sh;
  logic [26:0] ms;
  logic [23:0] r;
  logic [24:0] rr;
  logic [8:0]  ef;
  logic        sub;

  always_comb begin
    if (b[30:0] > a[30:0]) begin
      x = b; z = a;
    end else begin
      x = a; z = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ez = (z[30:23] == 8'd0) ? 8'd1 : z[30:23];
    mx = {(x[30:23] != 8'd0), x[22:0], 3'b000};
    mz = {(z[30:23] != 8'd0), z[22:0], 3'b000};
    d = ex - ez;
    mzm = (27'd1 << d[4:0]) - 27'd1;
    if (d >= 8'd27) mzs = {26'd0, (mz != 27'd0)};
    else mzs = (mz >> d[4:0]) | {26'd0, ((mz & mzm) != 27'd0)};
    sub = x[31] ^ z[31];
    sum = sub ? ({1'b0, mx} - {1'b0, mzs}) : ({1'b0, mx} + {1'b0, mzs});
    e = {1'b0, ex};
    m = sum[26:0];
    if (!sub && sum[27]) begin
      m = sum[27:1] | {26'd0, sum[0]};
      e = e + 9'd1;
    end
    lz = 5'd26;
    for (int i = 0; i < 27; i++) if (m[i]) lz = 5'(26 - i);
    sh = (e - 9'd1 < {4'd0, lz}) ? e - 9'd1 : {4'd0, lz};
    if (sub) begin
      ms = m << sh[4:0];
      ef = e - sh;
    end else begin
      ms = m;
      ef = e;
    end
    r = ms[26:3];
    rr = {1'b0, r} + {24'd0, (ms[2] && (ms[1:0] != 2'd0 || r[0]))};
    if (rr[24]) begin
      rr = rr >> 1;
      ef = ef + 9'd1;
    end
    if (!rr[23]) ef = 9'd0;
    if (ef >= 9'd255) y = {x[31], 31'h7F80_0000};
    else y = {x[31], ef[7:0], rr[22:0]};
    if (sub && sum == 28'd0) y = 32'd0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) y = {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'h7F80_0000) y = a;
    else if (b[30:0] == 31'h7F80_0000) y = b;
    if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000)
      y = (a[31] ^ b[31]) ? QNanDef : a;
    if (is_snan32(a)) y = a | QuietBit;
    else if (is_snan32(b)) y = b | QuietBit;
    else if (is_nan32(a)) y = a;
    else if (is_nan32(b)) y = b;
  end
endmodule

// ===== src/bf16_group_sum_fp32_accumulate.sv =====
// bf16 group sum with fp32 accumulator.
// Input channel in_valid/in_ready/in_value_bf16: one bf16 value per beat.
// Output channel out_valid/out_ready/out_sum_bf16: one bf16 sum per group.
// cfg_we/cfg_wdata set group_size (0 acts as 1, above MAX_GROUP as MAX_GROUP);
// write only while idle.
// Each beat is widened to fp32 and added into the accumulator in the cycle
// it is accepted: one beat per cycle sustained while in_ready is high. The fp32
// adder between the accumulator and its register sets that figure.
// The beat closing a group loads the result register; out_valid rises the
// next cycle. The accumulator clears at that same edge, so the
// next group proceeds while the result waits.
// If the receiver stalls with a result pending, input keeps flowing until
// another group would close; in_ready then drops until the result is taken.
// Reset: accumulator +0, count 0, group_size 16, no result pending.
module bf16_group_sum_fp32_accumulate #(
  parameter int unsigned MAX_GROUP = bgs_pkg::MaxGroupDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_value_bf16,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sum_bf16,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import bgs_pkg::*;
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);

  logic [4:0]    group_size_r;
  logic [31:0]   acc_r, acc_nxt;
  logic [CW-1:0] seen_r, size_eff;
  logic          last, fire;
  logic          out_valid_r;
  logic [15:0]   sum_r;

  always_comb begin
    if (group_size_r == 5'd0) size_eff = CW'(1);
    else if ({27'd0, group_size_r} > MAX_GROUP) size_eff = CW'(MAX_GROUP);
    else size_eff = CW'(group_size_r);
  end

  bgs_fp32_add u_add (.a(acc_r), .b({in_value_bf16, 16'd0}), .y(acc_nxt));

  assign last = ({1'b0, seen_r} + 1'b1) >= {1'b0, size_eff};
  assign in_ready = !(last && out_valid_r && !out_ready);
  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GroupSizeRst;
      acc_r <= 32'd0;
      seen_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) group_size_r <= cfg_wdata;
      if (fire && last) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (fire) begin
        if (last) begin
          acc_r <= 32'd0;
          seen_r <= '0;
        end else begin
          acc_r <= acc_nxt;
          seen_r <= seen_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last) sum_r <= to_bf16(acc_nxt);
  end

  assign out_valid = out_valid_r;
  assign out_sum_bf16 = sum_r;
endmodule

// ===== src/bgs_checker.sv =====
module bgs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sum_bf16
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_bf16))
    else $error("result dropped or changed under stall");
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");
endmodule

bind bf16_group_sum_fp32_accumulate bgs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_sum_bf16(out_sum_bf16)
);

// ===== tb/tb_bf16_group_sum_fp32_accumulate.sv =====
module tb_bf16_group_sum_fp32_accumulate;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_value_bf16 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_sum_bf16;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  bf16_group_sum_fp32_accumulate u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value_bf16(in_value_bf16),
    .out_valid(out_valid), .out_ready(out_ready), .out_sum_bf16(out_sum_bf16),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [4:0]  grp_size_q;
  logic [31:0] acc_q;
  int unsigned seen_q;
  logic [15:0] sum_queue[$];

  int err_cnt = 0;
  int beats_sent = 0;
  int sums_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic nan32(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] fp32_sum(input logic [31:0] a_in,
                                           input logic [31:0] b_in);
    logic [31:0] a, b, absa, absb, t, sgn, ea, eb, ma, mb, m, d, e, g;
    a = a_in; b = b_in;
    absa = a & 32'h7FFF_FFFF; absb = b & 32'h7FFF_FFFF;
    if (nan32(a) || nan32(b)) begin
      if (nan32(a) && !a[22]) return a | 32'h0040_0000;
      if (nan32(b) && !b[22]) return b | 32'h0040_0000;
      if (nan32(a)) return a;
      return b;
    end
    if (absa == 32'h7F80_0000 && absb == 32'h7F80_0000)
      return ((a ^ b) & 32'h8000_0000) ? 32'h7FC0_0000 : a;
    if (absa == 32'h7F80_0000) return a;
    if (absb == 32'h7F80_0000) return b;
    if (absa == 0 && absb == 0) return a & b & 32'h8000_0000;
    if (absb > absa) begin
      t = a; a = b; b = t; t = absa; absa = absb; absb = t;
    end
    sgn = a & 32'h8000_0000;
    ea = absa >> 23; eb = absb >> 23;
    ma = absa & 32'h007F_FFFF; mb = absb & 32'h007F_FFFF;
    if (ea != 0) ma |= 32'h0080_0000; else ea = 1;
    if (eb != 0) mb |= 32'h0080_0000; else eb = 1;
    ma <<= 3; mb <<= 3;
    d = ea - eb;
    if (d >= 27) mb = (mb != 0) ? 1 : 0;
    else if (d > 0) mb = (mb >> d) | ((mb & ((32'd1 << d) - 1)) != 0 ? 1 : 0);
    e = ea;
    if (((a ^ b) & 32'h8000_0000) == 0) begin
      m = ma + mb;
      if (m & 32'h0800_0000) begin
        m = (m >> 1) | (m & 1);
        e++;
      end
    end else begin
      m = ma - mb;
      if (m == 0) return 32'd0;
      while (m < 32'h0400_0000 && e > 1) begin
        m <<= 1;
        e--;
      end
    end
    g = m & 7;
    m >>= 3;
    if (g > 4 || (g == 4 && m[0])) m++;
    if (m & 32'h0100_0000) begin
      m >>= 1;
      e++;
    end
    if (e >= 255) return sgn | 32'h7F80_0000;
    if ((m & 32'h0080_0000) == 0) e = 0;
    return sgn | (e << 23) | (m & 32'h007F_FFFF);
  endfunction

  function automatic logic [15:0] round_bf16(input logic [31:0] x);
    logic [31:0] r;
    if (nan32(x)) return x[31:16] | 16'h0040;
    r = x + 32'h7FFF + {31'd0, x[16]};
    return r[31:16];
  endfunction

  function automatic void predict_beat(input logic [15:0] v);
    int unsigned eff;
    eff = grp_size_q;
    if (eff < 1) eff = 1;
    if (eff > bgs_pkg::MaxGroupDef) eff = bgs_pkg::MaxGroupDef;
    acc_q = fp32_sum(acc_q, {v, 16'h0000});
    if (seen_q + 1 >= eff) begin
      sum_queue.push_back(round_bf16(acc_q));
      acc_q = '0;
      seen_q = 0;
    end else begin
      seen_q++;
    end
  endfunction

  // in_valid stays high after a beat so the next one can follow directly;
  // callers that pause drop it themselves
  task automatic send_value(input logic [15:0] v);
    while (($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value_bf16 <= v;
    do @(posedge clk); while (!in_ready);
    predict_beat(v);
    beats_sent++;
  endtask

  task automatic drain_sums();
    in_valid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_group_size(input logic [4:0] gs);
    drain_sums();
    cfg_we <= 1'b1;
    cfg_wdata <= gs;
    @(posedge clk);
    cfg_we <= 1'b0;
    grp_size_q = gs;
  endtask

  // mostly ordinary finite values, some specials
  function automatic logic [15:0] rand_value();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 60) return {1'($urandom), 8'($urandom_range(110, 140)), 7'($urandom)};
    if (k < 70) return {1'($urandom), 8'h00, 7'($urandom)};
    if (k < 78) return {1'($urandom), 8'($urandom_range(250, 254)), 7'($urandom)};
    if (k < 84) return {1'($urandom), 15'h7F80};
    if (k < 88) return {1'($urandom), 8'hFF, 7'($urandom)};
    if (k < 92) return {1'($urandom), 15'h0000};
    return 16'($urandom);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sum_queue.size() == 0) begin
        $error("sum_bf16: unexpected beat, actual %h", out_sum_bf16);
        err_cnt++;
      end else begin
        if (out_sum_bf16 !== sum_queue[0]) begin
          $error("sum_bf16: expected %h actual %h", sum_queue[0], out_sum_bf16);
          err_cnt++;
        end
        void'(sum_queue.pop_front());
        sums_checked++;
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic test_directed_specials();
    logic [15:0] vals[$];
    set_group_size(5'd2);
    vals = '{16'h3F80, 16'hBF80, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
             16'h7F80, 16'hFF80, 16'h7F80, 16'h3F80, 16'h7F81, 16'h7FC1,
             16'h7FC2, 16'h7F82, 16'h0001, 16'h8001, 16'h7F7F, 16'h7F7F,
             16'hFFFF, 16'h0000, 16'h0001, 16'h0001};
    foreach (vals[i]) send_value(vals[i]);
    set_group_size(5'd1);
    send_value(16'hFFFF);
    send_value(16'h0000);
  endtask

  task automatic test_size_range();
    logic [4:0] sizes[$];
    sizes = '{5'd0, 5'd16, 5'd17, 5'd31, 5'd3};
    foreach (sizes[i]) begin
      set_group_size(sizes[i]);
      repeat (20) send_value(rand_value());
    end
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    set_group_size(5'($urandom_range(1, 16)));
    repeat (n) send_value(rand_value());
  endtask

  // size change mid-group: the next beat closes the group once count + 1 reaches or passes the new size
  task automatic test_midgroup_change();
    set_group_size(5'd8);
    repeat (5) send_value(rand_value());
    // partial group produces no sum; wait out the pipeline
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 5'd4;
    @(posedge clk);
    cfg_we <= 1'b0;
    grp_size_q = 5'd4;
    repeat (3) send_value(rand_value());
  endtask

  initial begin
    grp_size_q = bgs_pkg::GroupSizeRst;
    acc_q = '0;
    seen_q = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_specials();
    test_midgroup_change();
    test_size_range();
    test_random_phase(0, 0, 80);
    test_random_phase(61, 0, 80);
    test_random_phase(0, 61, 80);
    test_random_phase(24, 24, 80);
    drain_sums();
    repeat (10) @(posedge clk);
    $display("covered %0d input beats, %0d group sums, sizes 0..31, NaN/inf/zero cases",
             beats_sent, sums_checked);
    if (err_cnt == 0 && sum_queue.size() == 0) begin
      $display("bf16_group_sum_fp32_accumulate verification clean");
    end else begin
      $display("bf16_group_sum_fp32_accumulate verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("bf16_group_sum_fp32_accumulate verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
src/bgs_pkg.sv
src/bgs_fp32_add.sv
src/bf16_group_sum_fp32_accumulate.sv
src/bgs_checker.sv
tb/tb_bf16_group_sum_fp32_accumulate.sv
